FILE: sv/tlbm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlbm_pkg
// Shared types, codes and defaults for the tile latched bank mapper.
// ----------------------------------------------------------------------------
package tlbm_pkg;

    localparam int PROGRAM_BANKS_DEFAULT = 16;
    localparam int PATTERN_BANKS_DEFAULT = 32;

    // Access kinds
    localparam logic [1:0] KIND_CPU_READ  = 2'd0;
    localparam logic [1:0] KIND_CPU_WRITE = 2'd1;
    localparam logic [1:0] KIND_PPU_READ  = 2'd2;

    // Result targets
    localparam logic [1:0] TARGET_NONE    = 2'd0;
    localparam logic [1:0] TARGET_PRG_RAM = 2'd1;
    localparam logic [1:0] TARGET_PRG_ROM = 2'd2;
    localparam logic [1:0] TARGET_CHR_ROM = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] address;
        logic [7:0]  write_data;
    } req_t;

    typedef struct packed {
        logic [1:0]  target;
        logic [16:0] mapped_address;
        logic        mirror_horizontal;
    } rsp_t;

endpackage

FILE: sv/tlbm_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlbm_map
// Bank registers, tile latches and the address decode for one request.
// ----------------------------------------------------------------------------
module tlbm_map #(
    parameter int PROGRAM_BANKS = tlbm_pkg::PROGRAM_BANKS_DEFAULT,
    parameter int PATTERN_BANKS = tlbm_pkg::PATTERN_BANKS_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         advance,
    input  tlbm_pkg::req_t item,
    output tlbm_pkg::rsp_t result
);
    import tlbm_pkg::*;

    localparam int PRG_W = (PROGRAM_BANKS > 1) ? $clog2(PROGRAM_BANKS) : 1;
    localparam int CHR_W = (PATTERN_BANKS > 1) ? $clog2(PATTERN_BANKS) : 1;

    localparam logic [3:0]  PAGE_PRG_BANK = 4'hA;
    localparam logic [3:0]  PAGE_FD_LOW   = 4'hB;
    localparam logic [3:0]  PAGE_FE_LOW   = 4'hC;
    localparam logic [3:0]  PAGE_FD_HIGH  = 4'hD;
    localparam logic [3:0]  PAGE_FE_HIGH  = 4'hE;
    localparam logic [3:0]  PAGE_MIRROR   = 4'hF;

    localparam logic [12:0] TILE_FD_LOW    = 13'h0FD8;
    localparam logic [12:0] TILE_FE_LOW    = 13'h0FE8;
    localparam logic [12:0] TILE_FD_HIGH_A = 13'h1FD8;
    localparam logic [12:0] TILE_FD_HIGH_B = 13'h1FDF;
    localparam logic [12:0] TILE_FE_HIGH_A = 13'h1FE8;
    localparam logic [12:0] TILE_FE_HIGH_B = 13'h1FEF;

    logic [3:0]  prg_bank_reg,   prg_bank_next;
    logic [4:0]  fd_bank_reg     [2];
    logic [4:0]  fd_bank_next    [2];
    logic [4:0]  fe_bank_reg     [2];
    logic [4:0]  fe_bank_next    [2];
    logic [1:0]  latch_reg,      latch_next;
    logic [4:0]  active_reg      [2];
    logic [4:0]  active_next     [2];
    logic [4:0]  active_eff      [2];
    logic        pending_reg,    pending_next;
    logic        mirror_reg,     mirror_next;

    logic [PRG_W-1:0] prg_mod_tab [16];
    logic [CHR_W-1:0] chr_mod_tab [32];
    logic [PRG_W-1:0] prg_sel;
    logic [CHR_W-1:0] chr_sel;
    logic [31:0]      prg_rom_wide;
    logic [12:0]      ppu_addr;
    logic [3:0]       page;
    logic             ram_window;
    logic             tile_hit;

    // Constant reduction tables for out-of-range bank numbers
    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            prg_mod_tab[i] = PRG_W'(i % PROGRAM_BANKS);
        end
        for (int j = 0; j < 32; j++)
        begin
            chr_mod_tab[j] = CHR_W'(j % PATTERN_BANKS);
        end
    end

    assign ppu_addr   = item.address[12:0];
    assign page       = item.address[15:12];
    assign ram_window = (item.address[15:13] == 3'b011);

    // Pending latch switch lands before this read is mapped
    assign active_eff[0] = pending_reg ? fd_bank_reg[latch_reg[0]] : active_reg[0];
    assign active_eff[1] = pending_reg ? fe_bank_reg[latch_reg[1]] : active_reg[1];

    always_comb
    begin
        if (item.address[14:13] == 2'd0)
            prg_sel = prg_mod_tab[prg_bank_reg];
        else
            prg_sel = PRG_W'(PROGRAM_BANKS - 4) + PRG_W'(item.address[14:13]);
    end

    assign prg_rom_wide = (32'(prg_sel) << 13) | 32'(item.address[12:0]);
    assign chr_sel      = chr_mod_tab[active_eff[ppu_addr[12]]];

    assign tile_hit = (ppu_addr == TILE_FD_LOW) || (ppu_addr == TILE_FE_LOW)
                   || (ppu_addr >= TILE_FD_HIGH_A && ppu_addr <= TILE_FD_HIGH_B)
                   || (ppu_addr >= TILE_FE_HIGH_A && ppu_addr <= TILE_FE_HIGH_B);

    always_comb
    begin
        prg_bank_next   = prg_bank_reg;
        fd_bank_next[0] = fd_bank_reg[0];
        fd_bank_next[1] = fd_bank_reg[1];
        fe_bank_next[0] = fe_bank_reg[0];
        fe_bank_next[1] = fe_bank_reg[1];
        latch_next      = latch_reg;
        active_next[0]  = active_reg[0];
        active_next[1]  = active_reg[1];
        pending_next    = pending_reg;
        mirror_next     = mirror_reg;

        result.target         = TARGET_NONE;
        result.mapped_address = '0;

        unique case (item.kind)
            KIND_CPU_READ:
            begin
                if (item.address[15])
                begin
                    result.target         = TARGET_PRG_ROM;
                    result.mapped_address = prg_rom_wide[16:0];
                end
                else if (ram_window)
                begin
                    result.target         = TARGET_PRG_RAM;
                    result.mapped_address = {4'd0, item.address[12:0]};
                end
            end
            KIND_CPU_WRITE:
            begin
                if (ram_window)
                begin
                    result.target         = TARGET_PRG_RAM;
                    result.mapped_address = {4'd0, item.address[12:0]};
                end
                else
                begin
                    unique case (page)
                        PAGE_PRG_BANK: prg_bank_next = item.write_data[3:0];
                        PAGE_FD_LOW:   fd_bank_next[0] = item.write_data[4:0];
                        PAGE_FE_LOW:   fd_bank_next[1] = item.write_data[4:0];
                        PAGE_FD_HIGH:  fe_bank_next[0] = item.write_data[4:0];
                        PAGE_FE_HIGH:  fe_bank_next[1] = item.write_data[4:0];
                        PAGE_MIRROR:   mirror_next = item.write_data[0];
                        default:       ;
                    endcase
                    // Reload the active bank of the slot just written
                    if (page == PAGE_FD_LOW || page == PAGE_FE_LOW)
                        active_next[0] = fd_bank_next[latch_reg[0]];
                    if (page == PAGE_FD_HIGH || page == PAGE_FE_HIGH)
                        active_next[1] = fe_bank_next[latch_reg[1]];
                end
            end
            KIND_PPU_READ:
            begin
                active_next[0] = active_eff[0];
                active_next[1] = active_eff[1];
                pending_next   = tile_hit;
                if (ppu_addr == TILE_FD_LOW)
                    latch_next[0] = 1'b0;
                else if (ppu_addr == TILE_FE_LOW)
                    latch_next[0] = 1'b1;
                else if (ppu_addr >= TILE_FD_HIGH_A && ppu_addr <= TILE_FD_HIGH_B)
                    latch_next[1] = 1'b0;
                else if (ppu_addr >= TILE_FE_HIGH_A && ppu_addr <= TILE_FE_HIGH_B)
                    latch_next[1] = 1'b1;
                result.target         = TARGET_CHR_ROM;
                result.mapped_address = 17'({chr_sel, ppu_addr[11:0]});
            end
            default: ;
        endcase

        result.mirror_horizontal = mirror_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prg_bank_reg  <= '0;
            fd_bank_reg[0] <= '0;
            fd_bank_reg[1] <= '0;
            fe_bank_reg[0] <= '0;
            fe_bank_reg[1] <= '0;
            latch_reg     <= '0;
            active_reg[0] <= '0;
            active_reg[1] <= '0;
            pending_reg   <= 1'b0;
            mirror_reg    <= 1'b0;
        end
        else if (advance)
        begin
            prg_bank_reg  <= prg_bank_next;
            fd_bank_reg[0] <= fd_bank_next[0];
            fd_bank_reg[1] <= fd_bank_next[1];
            fe_bank_reg[0] <= fe_bank_next[0];
            fe_bank_reg[1] <= fe_bank_next[1];
            latch_reg     <= latch_next;
            active_reg[0] <= active_next[0];
            active_reg[1] <= active_next[1];
            pending_reg   <= pending_next;
            mirror_reg    <= mirror_next;
        end
    end

endmodule

FILE: sv/tile_latched_bank_mapper_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tile_latched_bank_mapper_core
// Bus access mapper with a switchable program bank and tile latched pattern
// banks; reports the landing memory, mapped byte address and mirroring.
// ----------------------------------------------------------------------------
//  channel   handshake             payload  role
//  request   req_valid/req_ready   req      one cpu read, cpu write or ppu read
//  response  rsp_valid/rsp_ready   rsp      target, mapped address, mirroring
//
//  One request per cycle sustained while responses are taken; a taken
//  request waits in the input register, moves to the result register once
//  that has room, and its response is offered from the result register.
//  The mapping path is the address decode and a bank multiplex between them.
//  rst_n clears the bank registers, tile latches and both valid flags.
//  A stalled response holds the result register; the input register keeps
//  accepting until it too is full, so back-pressure leaves no bubble.
// ----------------------------------------------------------------------------
module tile_latched_bank_mapper_core #(
    parameter int PROGRAM_BANKS = tlbm_pkg::PROGRAM_BANKS_DEFAULT,
    parameter int PATTERN_BANKS = tlbm_pkg::PATTERN_BANKS_DEFAULT
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  tlbm_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output tlbm_pkg::rsp_t rsp
);
    import tlbm_pkg::*;

    logic  in_valid_reg, in_valid_next;
    req_t  in_req_reg;
    logic  out_valid_reg, out_valid_next;
    rsp_t  out_rsp_reg;
    rsp_t  map_rsp;
    logic  advance;
    logic  take;

    // Advance the held request into the result register when it has room
    assign advance   = in_valid_reg && (!out_valid_reg || rsp_ready);
    assign req_ready = !in_valid_reg || advance;
    assign take      = req_valid && req_ready;

    tlbm_map #(
        .PROGRAM_BANKS (PROGRAM_BANKS),
        .PATTERN_BANKS (PATTERN_BANKS)
    ) u_map (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (in_req_reg),
        .result  (map_rsp)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (take)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (rsp_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: capture on transfer, hold otherwise
    always_ff @(posedge clk)
    begin
        if (take)
            in_req_reg <= req;
        if (advance)
            out_rsp_reg <= map_rsp;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_rsp_reg;

endmodule

FILE: sv/tlbm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlbm_checker
// Port level checks for the tile latched bank mapper, bound to the top level.
// ----------------------------------------------------------------------------
module tlbm_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_ready,
    input tlbm_pkg::req_t req,
    input logic           rsp_valid,
    input logic           rsp_ready,
    input tlbm_pkg::rsp_t rsp
);
    import tlbm_pkg::*;

    // Hold a waiting request
    a_req_hold: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_ready |=> req_valid && $stable(req))
        else $error("waiting request changed");

    // Hold a stalled response
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("stalled response changed");

    // After every taken request, the response valid flag must be high
    a_req_latency: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |-> ##2 rsp_valid)
        else $error("accepted request produced no response");

    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.target == TARGET_NONE |-> rsp.mapped_address == 17'd0)
        else $error("open bus response carries an address");

    a_ram_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.target == TARGET_PRG_RAM |-> rsp.mapped_address[16:13] == 4'd0)
        else $error("program ram address out of window");

endmodule

bind tile_latched_bank_mapper_core tlbm_checker u_tlbm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);
